FILE: rtl/ntwa_pkg.sv
// Shared constants, codes and controller/datapath interface types of the neighbor table.
package ntwa_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = 5;
    localparam int ADDR_W      = 8;
    localparam int RSSI_W      = 8;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 32;
    localparam int S_DATA_W    = 56;
    localparam int M_DATA_W    = 24;

    // Request types carried on the input tuser.
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_AGE    = 2'd1;
    localparam logic [1:0] REQ_REPORT = 2'd2;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_AGE    = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    // Update status codes.
    localparam logic [1:0] UPD_REFRESHED = 2'd0;
    localparam logic [1:0] UPD_INSERTED  = 2'd1;
    localparam logic [1:0] UPD_DROPPED   = 2'd2;
    localparam logic [1:0] UPD_IGNORED   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOCAL_ADDR   = 2'd0;
    localparam logic [1:0] CFG_INVALID_ADDR = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT      = 2'd2;

    localparam logic [ADDR_W-1:0] LOCAL_ADDR_RST   = 8'd0;
    localparam logic [ADDR_W-1:0] INVALID_ADDR_RST = 8'd255;
    localparam logic [TIME_W-1:0] TIMEOUT_RST      = 32'd10000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_AGE,
        S_AGE_OUT,
        S_RPT
    } state_t;

    typedef enum logic [1:0] {
        EM_UPDATE,
        EM_AGE,
        EM_RPT_ENTRY,
        EM_RPT_EMPTY
    } emit_t;

    typedef struct packed {
        logic       capture;
        logic       idx_inc;
        logic       note_free;
        logic       write_hit;
        logic       write_free;
        logic       clear_slot;
        logic       emit;
        emit_t      emit_sel;
        logic [1:0] emit_status;
        logic       emit_last;
    } ntwa_cmd_t;

    typedef struct packed {
        logic [1:0] in_type;
        logic       ignore;
        logic       slot_hit;
        logic       slot_free;
        logic       insert_ok;
        logic       last_idx;
        logic       expired;
        logic       used_here;
        logic       rpt_empty;
        logic       rpt_final;
        logic       out_room;
    } ntwa_stat_t;

endpackage

FILE: rtl/ntwa_ctrl.sv
// Controller state machine that sequences the slot scan for update, age and report requests.
module ntwa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ntwa_pkg::ntwa_stat_t stat,
    output ntwa_pkg::ntwa_cmd_t  cmd
);
    import ntwa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_tvalid && (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (stat.in_type)
                        REQ_UPDATE: state_next = S_UPD;
                        REQ_AGE:    state_next = S_AGE;
                        REQ_REPORT: state_next = S_RPT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_UPD: begin
                if (stat.ignore || stat.slot_hit || stat.last_idx) begin
                    if (stat.out_room) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_AGE: begin
                if (stat.last_idx) begin
                    state_next = S_AGE_OUT;
                end
            end
            S_AGE_OUT: begin
                if (stat.out_room) begin
                    state_next = S_IDLE;
                end
            end
            S_RPT: begin
                if (stat.rpt_empty) begin
                    if (stat.out_room) begin
                        state_next = S_IDLE;
                    end
                end else if (stat.used_here && stat.out_room && stat.rpt_final) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = (state_reg == S_IDLE);
        cmd             = '0;
        cmd.emit_sel    = EM_UPDATE;
        cmd.emit_status = UPD_REFRESHED;
        case (state_reg)
            S_IDLE: begin
                cmd.capture = accept;
            end
            S_UPD: begin
                cmd.emit_sel = EM_UPDATE;
                if (stat.ignore) begin
                    cmd.emit        = stat.out_room;
                    cmd.emit_status = UPD_IGNORED;
                end else if (stat.slot_hit) begin
                    cmd.emit        = stat.out_room;
                    cmd.write_hit   = stat.out_room;
                    cmd.emit_status = UPD_REFRESHED;
                end else if (stat.last_idx) begin
                    cmd.emit        = stat.out_room;
                    cmd.write_free  = stat.out_room && stat.insert_ok;
                    cmd.emit_status = stat.insert_ok ? UPD_INSERTED : UPD_DROPPED;
                end else begin
                    cmd.note_free = stat.slot_free;
                    cmd.idx_inc   = 1'b1;
                end
            end
            S_AGE: begin
                cmd.clear_slot = stat.expired;
                cmd.idx_inc    = !stat.last_idx;
            end
            S_AGE_OUT: begin
                cmd.emit     = stat.out_room;
                cmd.emit_sel = EM_AGE;
            end
            S_RPT: begin
                if (stat.rpt_empty) begin
                    cmd.emit     = stat.out_room;
                    cmd.emit_sel = EM_RPT_EMPTY;
                end else if (stat.used_here) begin
                    cmd.emit      = stat.out_room;
                    cmd.emit_sel  = EM_RPT_ENTRY;
                    cmd.emit_last = stat.rpt_final;
                    cmd.idx_inc   = stat.out_room && !stat.rpt_final;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            default: begin
                cmd.capture = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/ntwa_dp.sv
// Datapath: configuration registers, slot storage, scan index, counters and the output register.
module ntwa_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [ntwa_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic [ntwa_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [1:0]                     s_tuser,
    input  ntwa_pkg::ntwa_cmd_t            cmd,
    output ntwa_pkg::ntwa_stat_t           stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ntwa_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [2:0]                     m_tuser,
    output logic                           m_tlast
);
    import ntwa_pkg::*;

    logic [ADDR_W-1:0] local_addr_reg;
    logic [ADDR_W-1:0] invalid_addr_reg;
    logic [TIME_W-1:0] timeout_reg;

    logic [TABLE_DEPTH-1:0]  used_reg;
    logic [ADDR_W-1:0]       addr_mem_reg [TABLE_DEPTH];
    logic signed [RSSI_W-1:0] rssi_mem_reg [TABLE_DEPTH];
    logic [TIME_W-1:0]       time_mem_reg [TABLE_DEPTH];

    logic [ADDR_W-1:0]        req_addr_reg;
    logic signed [RSSI_W-1:0] req_rssi_reg;
    logic [TIME_W-1:0]        req_now_reg;
    logic [CNT_W-1:0]         req_limit_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             free_found_reg;
    logic [CNT_W-1:0] count_reg;

    logic                     out_valid_reg;
    logic [1:0]               out_kind_reg;
    logic [1:0]               out_status_reg;
    logic                     out_entry_valid_reg;
    logic [ADDR_W-1:0]        out_addr_reg;
    logic signed [RSSI_W-1:0] out_rssi_reg;
    logic [CNT_W-1:0]         out_count_reg;
    logic                     out_last_reg;

    logic [ADDR_W-1:0]        in_addr;
    logic signed [RSSI_W-1:0] in_rssi;
    logic [TIME_W-1:0]        in_now;
    logic [CNT_W-1:0]         in_limit;
    logic [TIME_W-1:0]        age_diff;
    logic [CNT_W-1:0]         count_plus;
    logic                     used_above;
    logic [IDX_W-1:0]         ins_idx;
    logic                     used_here;
    logic                     out_room;

    assign in_addr  = s_tdata[7:0];
    assign in_rssi  = s_tdata[15:8];
    assign in_now   = s_tdata[47:16];
    assign in_limit = s_tdata[52:48];

    assign used_here  = used_reg[idx_reg];
    assign age_diff   = req_now_reg - time_mem_reg[idx_reg];
    assign count_plus = count_reg + CNT_W'(1);
    assign ins_idx    = free_found_reg ? free_idx_reg : idx_reg;
    assign out_room   = !out_valid_reg || m_tready;

    // Any used slot beyond the current scan position keeps the report going; without one it ends.
    always_comb begin
        used_above = 1'b0;
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (used_reg[j] && (j > int'(idx_reg))) begin
                used_above = 1'b1;
            end
        end
    end

    always_comb begin
        stat.in_type   = s_tuser;
        stat.ignore    = (req_addr_reg == invalid_addr_reg) || (req_addr_reg == local_addr_reg);
        stat.slot_hit  = used_here && (addr_mem_reg[idx_reg] == req_addr_reg);
        stat.slot_free = !used_here;
        stat.insert_ok = free_found_reg || !used_here;
        stat.last_idx  = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
        stat.expired   = used_here && (age_diff > timeout_reg);
        stat.used_here = used_here;
        stat.rpt_empty = (req_limit_reg == '0) || (used_reg == '0);
        stat.rpt_final = (count_plus == req_limit_reg) || !used_above;
        stat.out_room  = out_room;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_addr_reg   <= LOCAL_ADDR_RST;
            invalid_addr_reg <= INVALID_ADDR_RST;
            timeout_reg      <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LOCAL_ADDR:   local_addr_reg   <= cfg_wr_data[ADDR_W-1:0];
                CFG_INVALID_ADDR: invalid_addr_reg <= cfg_wr_data[ADDR_W-1:0];
                CFG_TIMEOUT:      timeout_reg      <= cfg_wr_data[TIME_W-1:0];
                default:          timeout_reg      <= timeout_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (cmd.write_free) begin
            used_reg[ins_idx] <= 1'b1;
        end else if (cmd.clear_slot) begin
            used_reg[idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_hit) begin
            rssi_mem_reg[idx_reg] <= req_rssi_reg;
            time_mem_reg[idx_reg] <= req_now_reg;
        end else if (cmd.write_free) begin
            addr_mem_reg[ins_idx] <= req_addr_reg;
            rssi_mem_reg[ins_idx] <= req_rssi_reg;
            time_mem_reg[ins_idx] <= req_now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_addr_reg   <= in_addr;
            req_rssi_reg   <= in_rssi;
            req_now_reg    <= in_now;
            req_limit_reg  <= in_limit;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
        end else begin
            if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.note_free && !free_found_reg) begin
                free_idx_reg   <= idx_reg;
                free_found_reg <= 1'b1;
            end
            if (cmd.clear_slot || (cmd.emit && (cmd.emit_sel == EM_RPT_ENTRY))) begin
                count_reg <= count_plus;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_status_reg      <= UPD_REFRESHED;
            out_entry_valid_reg <= 1'b0;
            out_addr_reg        <= '0;
            out_rssi_reg        <= '0;
            out_count_reg       <= '0;
            out_last_reg        <= 1'b1;
            case (cmd.emit_sel)
                EM_UPDATE: begin
                    out_kind_reg   <= KIND_UPDATE;
                    out_status_reg <= cmd.emit_status;
                end
                EM_AGE: begin
                    out_kind_reg  <= KIND_AGE;
                    out_count_reg <= count_reg;
                end
                EM_RPT_ENTRY: begin
                    out_kind_reg        <= KIND_REPORT;
                    out_entry_valid_reg <= 1'b1;
                    out_addr_reg        <= addr_mem_reg[idx_reg];
                    out_rssi_reg        <= rssi_mem_reg[idx_reg];
                    out_count_reg       <= count_plus;
                    out_last_reg        <= cmd.emit_last;
                end
                default: begin
                    out_kind_reg <= KIND_REPORT;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_rssi_reg, out_addr_reg, out_status_reg};
    assign m_tuser  = {out_entry_valid_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/neighbor_table_with_aging_core.sv
// Top level of the neighbor table with timeout aging: controller plus datapath.
// An update result is registered once the request is found to be ignored, hits a slot or
// the scan reaches the last slot; an age summary follows the full scan, and report entries
// follow at one slot per cycle of the scan while the output has room. Throughput: one
// request at a time; the slot scan of one entry per cycle sets the pace, held by output stalls.
// Reset (aresetn low, synchronous) clears all used marks, the output valid and the
// controller state, and loads the configuration registers with their defaults.
module neighbor_table_with_aging_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port: index 0 local address, 1 invalid address, 2 timeout in ms.
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [ntwa_pkg::CFG_W-1:0]     cfg_wr_data,
    // Request stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: neighbor_addr [7:0], signal_rssi [15:8], now_ms [47:16],
    //          report_limit [52:48], zero padding [55:53].
    input  logic [ntwa_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: req_type [1:0].
    input  logic [1:0]                     s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: update_status [1:0], entry_addr [9:2], entry_rssi [17:10],
    //          running_count [22:18], zero padding [23].
    output logic [ntwa_pkg::M_DATA_W-1:0]  m_tdata,
    // m_tuser: result_kind [1:0], entry_valid [2].
    output logic [2:0]                     m_tuser,
    output logic                           m_tlast
);
    import ntwa_pkg::*;

    // The controller walks the slot index one entry per cycle unless the output stalls and
    // issues commands; the datapath holds the table and answers with status about the current slot.
    ntwa_cmd_t  cmd;
    ntwa_stat_t stat;

    // Sequencing of update, age and report scans. A new word is taken only when the
    // previous request has placed its final result into the output register.
    ntwa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Slot storage and the output register. The output register lets the block return
    // to idle and take the next word while a finished result still waits for m_tready.
    ntwa_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: rtl/ntwa_checker.sv
// Port-level checker for the neighbor table core and the bind that attaches it.
module ntwa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ntwa_pkg::M_DATA_W-1:0] m_tdata,
    input logic [2:0]                    m_tuser,
    input logic                          m_tlast
);
    import ntwa_pkg::*;

    // A stalled word holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Update and age requests give exactly one result, so it is always the last.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == KIND_UPDATE || m_tuser[1:0] == KIND_AGE) |-> m_tlast)
        else $error("single result without last mark");

    // An empty report is a lone closing word with a zero count.
    a_empty_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == KIND_REPORT) && !m_tuser[2]
            |-> m_tlast && (m_tdata[22:18] == '0) && (m_tdata[9:2] == '0))
        else $error("malformed empty report");

    // A real report entry counts itself, so its running count is never zero.
    a_entry_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == KIND_REPORT) && m_tuser[2] |-> (m_tdata[22:18] != '0))
        else $error("report entry with zero running count");

    // Only report results carry the entry flag.
    a_entry_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> (m_tuser[1:0] == KIND_REPORT) && (m_tdata[1:0] == '0))
        else $error("entry flag on a non-report result");

endmodule

bind neighbor_table_with_aging_core ntwa_checker u_ntwa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: tb/neighbor_table_with_aging_core_checker.sv
// Checker for the neighbor table: mirrors the table, predicts result words and compares them.
`timescale 1ns / 100ps
module neighbor_table_with_aging_core_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_index,
    input  logic [ntwa_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // s_tdata: neighbor_addr, signal_rssi, now_ms, report_limit, zero padding.
    input  logic [ntwa_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: req_type.
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: update_status, entry_addr, entry_rssi, running_count, zero padding.
    input  logic [ntwa_pkg::M_DATA_W-1:0]   m_tdata,
    // m_tuser: result_kind, entry_valid.
    input  logic [2:0]                      m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              words_due
);
    import ntwa_pkg::*;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        status;
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [RSSI_W-1:0] rssi;
        logic [CNT_W-1:0]  count;
        logic              last;
    } table_word_t;

    logic [ADDR_W-1:0] own_addr;
    logic [ADDR_W-1:0] reserved_addr;
    logic [TIME_W-1:0] age_limit;

    logic              used_mark [TABLE_DEPTH];
    logic [ADDR_W-1:0] nb_addr   [TABLE_DEPTH];
    logic [RSSI_W-1:0] nb_rssi   [TABLE_DEPTH];
    logic [TIME_W-1:0] nb_seen   [TABLE_DEPTH];

    table_word_t due_words [$];
    int          mismatches = 0;

    task automatic flag_error(input string msg);
        $display("%0t ns: ERROR %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int want, input int seen);
        if (want != seen) begin
            flag_error($sformatf("%s expected %0d, got %0d", name, want, seen));
        end
    endtask

    // Applies one request to the mirrored table and queues the words it must produce.
    task automatic table_step(input logic [1:0] req, input logic [S_DATA_W-1:0] word);
        logic [ADDR_W-1:0] addr;
        logic [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0] now;
        logic [CNT_W-1:0]  limit;
        logic [TIME_W-1:0] gap;
        table_word_t       w;
        int                hit;
        int                free_slot;
        int                total;
        int                n;
        addr  = word[7:0];
        rssi  = word[15:8];
        now   = word[47:16];
        limit = word[52:48];
        w      = '0;
        w.last = 1'b1;
        case (req)
            REQ_UPDATE: begin
                w.kind = KIND_UPDATE;
                if (addr == reserved_addr || addr == own_addr) begin
                    w.status = UPD_IGNORED;
                end else begin
                    hit       = -1;
                    free_slot = -1;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (hit < 0 && used_mark[i] && nb_addr[i] == addr) hit = i;
                        if (free_slot < 0 && !used_mark[i]) free_slot = i;
                    end
                    if (hit >= 0) begin
                        nb_rssi[hit] = rssi;
                        nb_seen[hit] = now;
                        w.status     = UPD_REFRESHED;
                    end else if (free_slot >= 0) begin
                        used_mark[free_slot] = 1'b1;
                        nb_addr[free_slot]   = addr;
                        nb_rssi[free_slot]   = rssi;
                        nb_seen[free_slot]   = now;
                        w.status             = UPD_INSERTED;
                    end else begin
                        w.status = UPD_DROPPED;
                    end
                end
                due_words.push_back(w);
            end
            REQ_AGE: begin
                w.kind = KIND_AGE;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    gap = now - nb_seen[i];
                    if (used_mark[i] && gap > age_limit) begin
                        used_mark[i] = 1'b0;
                        w.count++;
                    end
                end
                due_words.push_back(w);
            end
            REQ_REPORT: begin
                w.kind = KIND_REPORT;
                total  = 0;
                foreach (used_mark[i]) if (used_mark[i]) total++;
                if (total > int'(limit)) total = int'(limit);
                if (total == 0) begin
                    due_words.push_back(w);
                end else begin
                    n = 0;
                    for (int i = 0; i < TABLE_DEPTH && n < total; i++) begin
                        if (used_mark[i]) begin
                            n++;
                            w.valid = 1'b1;
                            w.addr  = nb_addr[i];
                            w.rssi  = nb_rssi[i];
                            w.count = CNT_W'(n);
                            w.last  = (n == total);
                            due_words.push_back(w);
                        end
                    end
                end
            end
            default: ;  // an unused request code changes nothing and yields no word
        endcase
    endtask

    task automatic check_word();
        table_word_t want;
        if (due_words.size() == 0) begin
            flag_error("result word arrived with nothing expected");
        end else begin
            want = due_words.pop_front();
            compare_field("result_kind", want.kind, m_tuser[1:0]);
            compare_field("update_status", want.status, m_tdata[1:0]);
            compare_field("entry_valid", want.valid, m_tuser[2]);
            compare_field("entry_addr", want.addr, m_tdata[9:2]);
            compare_field("entry_rssi", int'($signed(want.rssi)),
                          int'($signed(m_tdata[17:10])));
            compare_field("running_count", want.count, m_tdata[22:18]);
            compare_field("last", want.last, m_tlast);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            own_addr      = LOCAL_ADDR_RST;
            reserved_addr = INVALID_ADDR_RST;
            age_limit     = TIMEOUT_RST;
            foreach (used_mark[i]) used_mark[i] = 1'b0;
            due_words.delete();
        end else begin
            if (m_tvalid && m_tready) check_word();
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LOCAL_ADDR:   own_addr      = cfg_wr_data[ADDR_W-1:0];
                    CFG_INVALID_ADDR: reserved_addr = cfg_wr_data[ADDR_W-1:0];
                    CFG_TIMEOUT:      age_limit     = cfg_wr_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) table_step(s_tuser, s_tdata);
        end
        words_due  <= due_words.size();
        fail_count <= mismatches;
    end

endmodule

FILE: tb/neighbor_table_with_aging_core_tb.sv
// Top of the neighbor table testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 100ps
module neighbor_table_with_aging_core_tb;
    import ntwa_pkg::*;

    // The block defines no name for the fourth request code; it must be ignored silently.
    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    // The pause outlasts the slowest request, so it lets a silently dropped request
    // finish before the configuration changes.
    localparam int         SETTLE_CYCLES = 24;
    // This limit is many times what a correct run needs.
    localparam int         CYCLE_LIMIT   = 400000;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [1:0]           cfg_index   = CFG_LOCAL_ADDR;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata     = '0;
    logic [1:0]           s_tuser     = REQ_UPDATE;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    int                   fail_count;
    int                   words_due;
    int                   cycle_count = 0;

    // Random idling on both channels; cleared for one whole phase to run at full rate.
    bit                   idle_on     = 1'b1;

    // Copies of what was last written to the registers, used to steer the addresses.
    logic [ADDR_W-1:0]    cur_local   = LOCAL_ADDR_RST;
    logic [ADDR_W-1:0]    cur_invalid = INVALID_ADDR_RST;
    logic [TIME_W-1:0]    cur_timeout = TIMEOUT_RST;
    // Time base of the random phases; moves on after every update from the address pool.
    logic [TIME_W-1:0]    clock_ms    = 32'hFFFF_8000;

    neighbor_table_with_aging_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    neighbor_table_with_aging_core_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .words_due   (words_due)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The result side stalls at random on about a third of the cycles. It changes only on
    // the falling edge, so the block always sees a settled ready at the rising edge.
    always @(negedge aclk) begin
        m_tready <= !(idle_on && $urandom_range(0, 99) < 36);
    end

    // Watchdog: a hung handshake or a missing result word ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("neighbor_table_with_aging_core verification failed");
            $finish;
        end
    end

    // Offers one request word and returns at the rising edge that accepts it. The valid is
    // left high on return; the next call or the end of the phase decides what follows, so
    // that back-to-back words never see valid dropped and raised in one step. While idling,
    // the data lines carry junk to show that nothing is taken without valid.
    task automatic send_request(input logic [1:0] req, input logic [ADDR_W-1:0] addr,
                                input logic [RSSI_W-1:0] rssi, input logic [TIME_W-1:0] now,
                                input logic [CNT_W-1:0] limit);
        @(negedge aclk);
        while (idle_on && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_DATA_W'({$urandom, $urandom});
            s_tuser  <= 2'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, limit, now, rssi, addr};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Ends a phase: stops offering words, waits until every expected word has come and
    // then gives the block time to finish any request that produces no word at all.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One random phase. Most words are updates from a small address pool, which is larger
    // than the table so that it fills up, drops neighbors and refreshes known ones; time
    // moves in steps sized to the timeout so that aging frees some entries but not all.
    // The rest are ages, reports of every length, updates with random content and words
    // with the unused request code, which do not count toward the phase length.
    task automatic run_phase(input int count);
        logic [ADDR_W-1:0] pool [24];
        logic [TIME_W-1:0] step_max;
        int                done;
        int                pick;
        done     = 0;
        step_max = (cur_timeout > 32'h0600_0000) ? 32'h0100_0000 : cur_timeout / 6 + 32'd3;
        foreach (pool[i]) pool[i] = ADDR_W'($urandom_range(0, 255));
        pool[0] = cur_local;
        pool[1] = cur_invalid;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_request(REQ_UPDATE, pool[$urandom_range(0, 23)], RSSI_W'($urandom),
                             clock_ms, CNT_W'($urandom_range(0, 16)));
                clock_ms += $urandom_range(0, step_max);
            end else if (pick < 65) begin
                send_request(REQ_UPDATE, ADDR_W'($urandom), RSSI_W'($urandom), $urandom,
                             CNT_W'($urandom_range(0, 16)));
            end else if (pick < 77) begin
                send_request(REQ_AGE, ADDR_W'($urandom), RSSI_W'($urandom),
                             (pick < 75) ? clock_ms : $urandom,
                             CNT_W'($urandom_range(0, 16)));
            end else if (pick < 92) begin
                send_request(REQ_REPORT, ADDR_W'($urandom), RSSI_W'($urandom), $urandom,
                             CNT_W'($urandom_range(0, 16)));
            end else begin
                send_request(REQ_UNUSED, ADDR_W'($urandom), RSSI_W'($urandom), $urandom,
                             CNT_W'($urandom_range(0, 16)));
            end
            if (pick < 92) done++;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, with the registers at their reset values (local address 0,
        // invalid address 255, timeout 10000 ms).
        // An empty table reports one empty word and ages nothing.
        send_request(REQ_REPORT, 8'h00, 8'h00, 32'd0, 5'd16);
        send_request(REQ_AGE, 8'h00, 8'h00, 32'd0, 5'd0);
        // The invalid and the local address are ignored.
        send_request(REQ_UPDATE, 8'hFF, 8'h80, 32'd0, 5'd0);
        send_request(REQ_UPDATE, 8'h00, 8'h7F, 32'd0, 5'd0);
        // Two inserts at the RSSI extremes, then a refresh of the first.
        send_request(REQ_UPDATE, 8'h01, 8'h80, 32'd0, 5'd0);
        send_request(REQ_UPDATE, 8'hFE, 8'h7F, 32'd5, 5'd0);
        send_request(REQ_UPDATE, 8'h01, 8'h00, 32'd100, 5'd0);
        // A zero limit gives an empty word, a limit of one stops early, and a limit
        // above the number of entries reports them all.
        send_request(REQ_REPORT, 8'h00, 8'h00, 32'd0, 5'd0);
        send_request(REQ_REPORT, 8'h00, 8'h00, 32'd0, 5'd1);
        send_request(REQ_REPORT, 8'h00, 8'h00, 32'd0, 5'd16);
        // Fill the table, then one more neighbor has to be dropped.
        for (int a = 2; a < 16; a++) begin
            send_request(REQ_UPDATE, ADDR_W'(a), RSSI_W'($urandom), 32'd200 + a, 5'd0);
        end
        send_request(REQ_UPDATE, 8'hAB, 8'h11, 32'd10100, 5'd0);
        send_request(REQ_REPORT, 8'h00, 8'h00, 32'd0, 5'd16);
        // An age exactly at the timeout keeps the entry; one past it frees the entry.
        send_request(REQ_AGE, 8'h00, 8'h00, 32'd10100, 5'd0);
        send_request(REQ_UPDATE, 8'hAB, 8'h11, 32'd10100, 5'd0);
        send_request(REQ_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        // A time behind every entry wraps around and frees the whole table.
        send_request(REQ_AGE, 8'h00, 8'h00, 32'd50, 5'd0);
        send_request(REQ_REPORT, 8'h00, 8'h00, 32'd0, 5'd5);
        settle();

        // Zero timeout: any elapsed time frees an entry. The upper bits of the narrow
        // registers carry junk, which the block has to drop.
        cur_local   = 8'hFF;
        cur_invalid = 8'h00;
        cur_timeout = 32'd0;
        write_reg(CFG_LOCAL_ADDR, {24'($urandom), cur_local});
        write_reg(CFG_INVALID_ADDR, {24'($urandom), cur_invalid});
        write_reg(CFG_TIMEOUT, cur_timeout);
        run_phase(78);
        settle();

        // Longest timeout and local equal to invalid, at full rate on both channels.
        idle_on     = 1'b0;
        cur_local   = 8'h33;
        cur_invalid = 8'h33;
        cur_timeout = 32'hFFFF_FFFF;
        write_reg(CFG_LOCAL_ADDR, {24'($urandom), cur_local});
        write_reg(CFG_INVALID_ADDR, {24'($urandom), cur_invalid});
        write_reg(CFG_TIMEOUT, cur_timeout);
        run_phase(78);
        settle();
        idle_on     = 1'b1;

        // Short random timeout with the time base just below the wrap point.
        cur_local   = ADDR_W'($urandom_range(0, 255));
        cur_invalid = ADDR_W'($urandom_range(0, 255));
        cur_timeout = $urandom_range(50, 5000);
        clock_ms    = 32'hFFFF_FF00;
        write_reg(CFG_LOCAL_ADDR, {24'($urandom), cur_local});
        write_reg(CFG_INVALID_ADDR, {24'($urandom), cur_invalid});
        write_reg(CFG_TIMEOUT, cur_timeout);
        run_phase(78);
        settle();

        // Back to the reset addresses with a longer random timeout.
        cur_local   = LOCAL_ADDR_RST;
        cur_invalid = INVALID_ADDR_RST;
        cur_timeout = $urandom_range(20000, 2000000);
        write_reg(CFG_LOCAL_ADDR, {24'($urandom), cur_local});
        write_reg(CFG_INVALID_ADDR, {24'($urandom), cur_invalid});
        write_reg(CFG_TIMEOUT, cur_timeout);
        run_phase(78);
        settle();

        if (fail_count == 0) begin
            $display("neighbor_table_with_aging_core verification clean");
        end else begin
            $display("neighbor_table_with_aging_core verification failed");
        end
        $finish;
    end

endmodule
